### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fehg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fehg_pkg
// Grid geometry, item codes, sequencer states and address helper.
// ----------------------------------------------------------------------------
package fehg_pkg;

    localparam int GRID_W = 40;
    localparam int GRID_H = 34;
    localparam int COLS   = GRID_W + 1;
    localparam int ROWS   = GRID_H + 1;
    localparam int DEPTH  = COLS * ROWS;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam int HEAT_W    = 8;
    localparam int RSUM_W    = 10;   // three bytes
    localparam int SUM_W     = 12;   // nine bytes
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = 13;
    // ceil(2^16 / 9): exact truncated quotient for sums up to 9 * 255
    localparam int RECIP9    = (1 << DIV_SHIFT) / 9 + 1;

    typedef logic [1:0]        t_kind;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [HEAT_W-1:0] t_heat;

    localparam t_kind KIND_HOT   = 2'd0;
    localparam t_kind KIND_FRAME = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILT,
        S_FDRAIN,
        S_SHIFT,
        S_SDRAIN,
        S_BCLR
    } t_state;

    // column-major cell address
    function automatic t_addr f_cell(input t_col c, input t_row r);
        return ADDR_W'(int'(c) * ROWS + int'(r));
    endfunction

endpackage

### rtl/fire_effect_heat_grid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_effect_heat_grid_core
// Fire-effect heat grid: hot-spot writes, in-place 3x3 box filter with row
// scroll per frame, and single-cell reads, all on one simple dual-port memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ---------------------------
// command   in         start && !busy              i_kind i_column i_row i_heat
// result    out        o_valid, one-cycle strobe   o_cell_value o_rejected
//
// Single transactions: hot-spot, read and unused-kind transactions strobe their
//   result on the cycle after acceptance, and busy stays low.
// Frame: three filter reads per cell over columns 1..GRID_W-1 and all rows (one
//   memory read port, one byte a cycle), then drain, scroll, and the bottom-row
//   clear over columns 0..GRID_W; result strobes as busy drops.
// Reset: synchronous; the memory is then swept to zero, one cell a cycle,
//   all DEPTH cells, with busy high.
// Stalls: the receiver cannot stall; each result is valid for one cycle.
//
module fire_effect_heat_grid_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [5:0]            i_column,
    input  logic [5:0]            i_row,
    input  logic [7:0]            i_heat,
    output logic                  o_valid,
    output logic [7:0]            o_cell_value,
    output logic                  o_rejected
);
    import fehg_pkg::*;

    // column phase of a filter read: left, own, right neighbor column
    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_OWN   = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    localparam int PROD_W = SUM_W + RECIP_W;

    // heat memory, one write and one registered read per cycle
    t_heat r_mem [DEPTH];
    t_heat r_rd_data;

    t_state r_state, n_state;

    // shared walk counters
    t_col       r_col, n_col;
    t_row       r_row, n_row;
    logic [1:0] r_ph,  n_ph;
    t_addr      r_cnt, n_cnt;

    // result register
    logic r_out_v,   n_out_v;
    logic r_out_rd,  n_out_rd;
    logic r_out_rej, n_out_rej;

    // memory port controls
    logic  mem_we;
    t_addr mem_waddr;
    t_heat mem_wdata;
    t_addr mem_raddr;

    // filter pipeline
    logic              issue_filt;
    logic              r_v1;
    logic [1:0]        r_ph1;
    t_row              r_row1;
    t_col              r_col1;
    logic [RSUM_W-1:0] r_acc;
    logic [RSUM_W-1:0] r_sa;      // row sum two rows up
    logic [RSUM_W-1:0] r_sb;      // row sum one row up
    logic [RSUM_W-1:0] w_rowsum;
    logic [SUM_W-1:0]  r_tot;
    logic              r_tot_v;
    t_col              r_wcol;
    t_row              r_wrow;
    logic [PROD_W-1:0] w_prod;
    t_heat             w_quot;
    t_col              w_filt_col;

    // scroll pipeline
    logic  issue_shift;
    logic  r_sv;
    t_addr r_swaddr;

    logic accept;
    logic hot_ok;
    logic read_ok;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign hot_ok  = (i_column != 6'd0) && (int'(i_column) < GRID_W);
    assign read_ok = (int'(i_column) <= GRID_W) && (int'(i_row) <= GRID_H);

    assign w_filt_col = r_col + t_col'(r_ph) - t_col'(1);
    assign w_rowsum   = r_acc + RSUM_W'(r_rd_data);
    assign w_prod     = PROD_W'(r_tot) * PROD_W'(RECIP9);
    assign w_quot     = w_prod[DIV_SHIFT +: HEAT_W];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == t_addr'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && (i_kind == KIND_FRAME)) n_state = S_FILT;
            end
            S_FILT: begin
                if ((r_col == t_col'(GRID_W - 1)) && (r_row == t_row'(GRID_H)) &&
                    (r_ph == PH_RIGHT)) n_state = S_FDRAIN;
            end
            S_FDRAIN: begin
                if (!r_v1 && !r_tot_v) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if ((r_col == t_col'(GRID_W - 1)) && (r_row == t_row'(GRID_H - 1)))
                    n_state = S_SDRAIN;
            end
            S_SDRAIN: begin
                n_state = S_BCLR;
            end
            S_BCLR: begin
                if (r_col == t_col'(GRID_W)) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs: memory ports, counters, result
    // ------------------------------------------------------------------
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_ph        = r_ph;
        n_cnt       = r_cnt;
        n_out_v     = 1'b0;
        n_out_rd    = 1'b0;
        n_out_rej   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = '0;
        mem_raddr   = '0;
        issue_filt  = 1'b0;
        issue_shift = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                n_cnt     = r_cnt + t_addr'(1);
            end
            S_IDLE: begin
                mem_raddr = f_cell(t_col'(i_column), t_row'(i_row));
                if (accept) begin
                    case (i_kind)
                        KIND_HOT: begin
                            mem_we    = hot_ok;
                            mem_waddr = f_cell(t_col'(i_column), t_row'(GRID_H));
                            mem_wdata = i_heat;
                            n_out_v   = 1'b1;
                            n_out_rej = !hot_ok;
                        end
                        KIND_FRAME: begin
                            n_col = t_col'(1);
                            n_row = '0;
                            n_ph  = PH_LEFT;
                        end
                        KIND_READ: begin
                            n_out_v  = 1'b1;
                            n_out_rd = read_ok;
                        end
                        default: begin
                            n_out_v = 1'b1;
                        end
                    endcase
                end
            end
            S_FILT: begin
                mem_raddr  = f_cell(w_filt_col, r_row);
                issue_filt = 1'b1;
                if (r_ph == PH_RIGHT) begin
                    n_ph = PH_LEFT;
                    if (r_row == t_row'(GRID_H)) begin
                        n_row = '0;
                        n_col = r_col + t_col'(1);
                    end else begin
                        n_row = r_row + t_row'(1);
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_FDRAIN: begin
                n_col = t_col'(1);
                n_row = t_row'(1);
            end
            S_SHIFT: begin
                mem_raddr   = f_cell(r_col, r_row + t_row'(1));
                issue_shift = 1'b1;
                if (r_row == t_row'(GRID_H - 1)) begin
                    n_row = t_row'(1);
                    n_col = r_col + t_col'(1);
                end else begin
                    n_row = r_row + t_row'(1);
                end
            end
            S_SDRAIN: begin
                n_col = '0;
            end
            S_BCLR: begin
                mem_we    = 1'b1;
                mem_waddr = f_cell(r_col, t_row'(GRID_H));
                n_col     = r_col + t_col'(1);
                if (r_col == t_col'(GRID_W)) n_out_v = 1'b1;
            end
            default: begin
            end
        endcase

        // trailing writes of the filter and scroll pipelines
        if (r_tot_v) begin
            mem_we    = 1'b1;
            mem_waddr = f_cell(r_wcol, r_wrow);
            mem_wdata = w_quot;
        end
        if (r_sv) begin
            mem_we    = 1'b1;
            mem_waddr = r_swaddr;
            mem_wdata = r_rd_data;
        end
    end

    // ------------------------------------------------------------------
    // memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_col     <= '0;
            r_row     <= '0;
            r_ph      <= PH_LEFT;
            r_cnt     <= '0;
            r_out_v   <= 1'b0;
            r_out_rd  <= 1'b0;
            r_out_rej <= 1'b0;
            r_v1      <= 1'b0;
            r_tot_v   <= 1'b0;
            r_sv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_ph      <= n_ph;
            r_cnt     <= n_cnt;
            r_out_v   <= n_out_v;
            r_out_rd  <= n_out_rd;
            r_out_rej <= n_out_rej;
            r_v1      <= issue_filt;
            r_tot_v   <= r_v1 && (r_ph1 == PH_RIGHT) && (r_row1 >= t_row'(2));
            r_sv      <= issue_shift;
        end
    end

    // ------------------------------------------------------------------
    // filter datapath: one byte in per cycle, row sums slide down a column
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_ph1    <= r_ph;
        r_row1   <= r_row;
        r_col1   <= r_col;
        r_swaddr <= f_cell(r_col, r_row);
        if (r_v1) begin
            case (r_ph1)
                PH_LEFT: begin
                    r_acc <= RSUM_W'(r_rd_data);
                end
                PH_OWN: begin
                    r_acc <= w_rowsum;
                end
                PH_RIGHT: begin
                    r_sa   <= r_sb;
                    r_sb   <= w_rowsum;
                    r_tot  <= SUM_W'(r_sa) + SUM_W'(r_sb) + SUM_W'(w_rowsum);
                    r_wcol <= r_col1;
                    r_wrow <= r_row1 - t_row'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_cell_value = (r_out_v && r_out_rd) ? r_rd_data : '0;
    assign o_rejected   = r_out_v && r_out_rej;

endmodule

### rtl/fehg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fehg_checker
// Port-level checks on the heat grid core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fehg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_kind,
    input logic [5:0] i_column,
    input logic       o_valid,
    input logic       o_rejected
);
    import fehg_pkg::*;

    logic acc;
    logic bad_hot;

    assign acc     = start && !busy;
    assign bad_hot = (i_column == 6'd0) || (int'(i_column) >= GRID_W);

    `AST_NEXT(a_quick_result, acc && (i_kind != KIND_FRAME), o_valid, "missing result strobe")
    `AST_NEXT(a_frame_busy, acc && (i_kind == KIND_FRAME), busy && !o_valid, "frame not busy")
    `AST_SAME(a_valid_idle, o_valid, !busy, "result while busy")
    `AST_NEXT(a_reject, acc && (i_kind == KIND_HOT) && bad_hot, o_rejected, "edge not rejected")

endmodule

bind fire_effect_heat_grid_core fehg_checker u_fehg_checker (.*);

### bench/tb_fire_effect_heat_grid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fire_effect_heat_grid_core
// Self-checking bench for the fire-effect heat grid: hot-spot writes, frame
// advances (in-place 3x3 box filter, scroll up, bottom-row clear) and cell
// reads are driven through the start/busy port. A class mirrors the grid,
// predicts one result per accepted transaction and checks each o_valid strobe
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module tb_fire_effect_heat_grid_core;

    import fehg_pkg::*;

    // Kind 3 changes nothing in the grid but still returns a result.
    localparam t_kind KIND_UNUSED = 2'd3;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 4;
    localparam int TAIL_CYC    = 20;
    localparam int RAND_ITEMS  = 400;

    // ------------------------------------------------------------------------
    // Grid mirror and expected-result queue
    // ------------------------------------------------------------------------
    class heat_grid_tracker;

        typedef struct {
            logic [7:0] cell_value;
            logic       rejected;
        } t_grid_result;

        logic [7:0]   heat_cells [DEPTH];
        t_grid_result awaited_results [$];
        int           errors;
        int           n_hot;
        int           n_rej;
        int           n_frame;
        int           n_read;
        int           n_hot_reads;

        function new();
            foreach (heat_cells[i]) heat_cells[i] = 8'd0;
            errors      = 0;
            n_hot       = 0;
            n_rej       = 0;
            n_frame     = 0;
            n_read      = 0;
            n_hot_reads = 0;
        endfunction

        // Update the mirror for one accepted command and queue its result.
        function void note_command(t_kind kind, logic [5:0] col, logic [5:0] row,
                                   logic [7:0] heat);
            t_grid_result res;
            logic [7:0]   own [ROWS];
            int           c;
            int           r;
            int           k;
            int           sum;
            res.cell_value = 8'd0;
            res.rejected   = 1'b0;
            case (kind)
                KIND_HOT: begin
                    if (col >= 1 && col < GRID_W) begin
                        heat_cells[int'(col) * ROWS + GRID_H] = heat;
                        n_hot++;
                    end else begin
                        res.rejected = 1'b1;
                        n_rej++;
                    end
                end
                KIND_FRAME: begin
                    // left column already filtered, own and right columns old
                    for (c = 1; c < GRID_W; c++) begin
                        for (r = 0; r < ROWS; r++) own[r] = heat_cells[c * ROWS + r];
                        for (r = 1; r < GRID_H; r++) begin
                            sum = 0;
                            for (k = r - 1; k <= r + 1; k++) begin
                                sum += heat_cells[(c - 1) * ROWS + k];
                                sum += own[k];
                                sum += heat_cells[(c + 1) * ROWS + k];
                            end
                            heat_cells[c * ROWS + r] = 8'(sum / 9);
                        end
                    end
                    // scroll interior up, then clear the whole bottom row
                    for (c = 1; c < GRID_W; c++)
                        for (r = 1; r < GRID_H; r++)
                            heat_cells[c * ROWS + r] = heat_cells[c * ROWS + r + 1];
                    for (c = 0; c <= GRID_W; c++)
                        heat_cells[c * ROWS + GRID_H] = 8'd0;
                    n_frame++;
                end
                KIND_READ: begin
                    if (col <= GRID_W && row <= GRID_H)
                        res.cell_value = heat_cells[int'(col) * ROWS + int'(row)];
                    if (res.cell_value != 8'd0) n_hot_reads++;
                    n_read++;
                end
                default: ;
            endcase
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [7:0] cell_value, logic rejected);
            t_grid_result want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %0d rej %0d",
                         $time, cell_value, rejected);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (cell_value !== want.cell_value) begin
                $display("%0t: o_cell_value mismatch: expected %0d actual %0d",
                         $time, want.cell_value, cell_value);
                errors++;
            end
            if (rejected !== want.rejected) begin
                $display("%0t: o_rejected mismatch: expected %0d actual %0d",
                         $time, want.rejected, rejected);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_kind;
    logic [5:0] i_column;
    logic [5:0] i_row;
    logic [7:0] i_heat;
    logic       o_valid;
    logic [7:0] o_cell_value;
    logic       o_rejected;

    heat_grid_tracker grid_mirror;

    fire_effect_heat_grid_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_heat       (i_heat),
        .o_valid      (o_valid),
        .o_cell_value (o_cell_value),
        .o_rejected   (o_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Results cannot be stalled: every strobe is a transaction. Outputs are
    // sampled right after the edge, before the DUT's NBAs land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) grid_mirror.check_result(o_cell_value, o_rejected);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Present one command, hold it until the edge where start && !busy, then
    // optionally drop start for a gap. Start stays high between back-to-back
    // transactions, so it never gets two NBAs in one step.
    task automatic send_command(t_kind kind, logic [5:0] col, logic [5:0] row,
                                logic [7:0] heat, int gap);
        start    <= 1'b1;
        i_kind   <= kind;
        i_column <= col;
        i_row    <= row;
        i_heat   <= heat;
        do @(posedge i_clk); while (busy);
        grid_mirror.note_command(kind, col, row, heat);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (grid_mirror.pending() != 0) @(posedge i_clk);
    endtask

    // One random command, weighted toward well-formed hot-spot/frame/read
    // traffic; reads lean on the lower rows where heat survives the filter.
    // Each cycle after a transaction the sender idles with idle_pct odds.
    task automatic send_random(int idle_pct);
        int         pick;
        int         gap;
        t_kind      kind;
        logic [5:0] col;
        logic [5:0] row;
        logic [7:0] heat;
        pick = $urandom_range(99);
        col  = 6'($urandom_range(63));
        row  = 6'($urandom_range(63));
        heat = 8'($urandom_range(255));
        if (pick < 50) begin
            kind = KIND_HOT;
            if ($urandom_range(9) != 0) col = 6'($urandom_range(GRID_W - 1, 1));
            else if ($urandom_range(1) == 0) col = 6'd0;
            else col = 6'($urandom_range(63, GRID_W));
        end else if (pick < 57) begin
            kind = KIND_FRAME;
        end else if (pick < 96) begin
            kind = KIND_READ;
            if ($urandom_range(99) < 85) begin
                col = 6'($urandom_range(GRID_W));
                if ($urandom_range(99) < 70) row = 6'($urandom_range(GRID_H, GRID_H - 6));
                else row = 6'($urandom_range(GRID_H));
            end
        end else begin
            kind = KIND_UNUSED;
        end
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        send_command(kind, col, row, heat, gap);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int n;
        grid_mirror = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_kind   = KIND_HOT;
        i_column = 6'd0;
        i_row    = 6'd0;
        i_heat   = 8'd0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cleared grid, field extremes, rejects, out-of-grid reads,
        // unused kind, edge cells and two frames.
        send_command(KIND_READ,   6'd0,  6'd0,  8'd0,   0);
        send_command(KIND_READ,   6'd40, 6'd34, 8'd0,   0);
        send_command(KIND_HOT,    6'd1,  6'd0,  8'd255, 0);
        send_command(KIND_HOT,    6'd39, 6'd63, 8'd255, 0);
        send_command(KIND_HOT,    6'd20, 6'd0,  8'd128, 1);
        send_command(KIND_HOT,    6'd21, 6'd0,  8'd1,   0);
        send_command(KIND_HOT,    6'd0,  6'd0,  8'd77,  0);   // left edge
        send_command(KIND_HOT,    6'd40, 6'd0,  8'd77,  0);   // right edge
        send_command(KIND_HOT,    6'd63, 6'd63, 8'd255, 2);   // beyond grid
        send_command(KIND_READ,   6'd1,  6'd34, 8'd0,   0);
        send_command(KIND_READ,   6'd39, 6'd34, 8'd255, 0);
        send_command(KIND_READ,   6'd40, 6'd34, 8'd0,   0);
        send_command(KIND_READ,   6'd41, 6'd0,  8'd0,   0);   // column off grid
        send_command(KIND_READ,   6'd0,  6'd35, 8'd0,   0);   // row off grid
        send_command(KIND_READ,   6'd63, 6'd63, 8'd0,   0);
        send_command(KIND_UNUSED, 6'd63, 6'd63, 8'd255, 0);
        send_command(KIND_FRAME,  6'd0,  6'd0,  8'd0,   0);
        send_command(KIND_READ,   6'd1,  6'd33, 8'd0,   0);
        send_command(KIND_READ,   6'd20, 6'd32, 8'd0,   0);
        send_command(KIND_READ,   6'd1,  6'd34, 8'd0,   0);   // bottom row cleared
        send_command(KIND_READ,   6'd0,  6'd33, 8'd0,   3);   // edge column untouched
        send_command(KIND_FRAME,  6'd63, 6'd63, 8'd255, 0);
        send_command(KIND_READ,   6'd20, 6'd31, 8'd0,   0);
        send_command(KIND_READ,   6'd39, 6'd32, 8'd0,   0);

        // Random: sender idles lightly, then heavily, then not at all, with a
        // full drain of pending results in between.
        for (n = 0; n < RAND_ITEMS / 3; n++) send_random(36);
        wait_drained();
        for (n = 0; n < RAND_ITEMS / 3; n++) send_random(61);
        wait_drained();
        for (n = 0; n < RAND_ITEMS - 2 * (RAND_ITEMS / 3); n++) send_random(0);

        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Covered %0d hot spots, %0d rejects, %0d frames, %0d reads (%0d nonzero).",
                 grid_mirror.n_hot, grid_mirror.n_rej, grid_mirror.n_frame,
                 grid_mirror.n_read, grid_mirror.n_hot_reads);
        if (grid_mirror.errors == 0 && grid_mirror.pending() == 0) begin
            $display("** fire_effect_heat_grid_core: PASSED **");
        end else begin
            $display("** fire_effect_heat_grid_core: FAILED **");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run (clear sweep plus every
    // transaction a frame).
    initial begin
        #250_000_000;
        $display("Timeout with %0d results still pending.", grid_mirror.pending());
        $display("** fire_effect_heat_grid_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fehg_pkg.sv
rtl/fire_effect_heat_grid_core.sv
rtl/fehg_checker.sv
bench/tb_fire_effect_heat_grid_core.sv
